FILE: design/sha256_pkg.sv
// Shared types, constants and functions for the SHA-256 message hasher.
package sha256_pkg;

  localparam int unsigned DigestWords = 8;
  localparam int unsigned BlockWords  = 16;
  localparam int unsigned Rounds      = 64;
  localparam logic [7:0]  PadMark     = 8'h80;
  localparam logic [5:0]  LenPos      = 6'd56;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_end;
    logic       message_empty;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        digest_done;
  } sha_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_LEN,
    ST_EMIT
  } sha_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_byte;  // write accepted byte into block
    logic pad_start;  // write pad mark and clear rest of block
    logic clear_blk;  // zero words 0 to 13 (second padding block)
    logic put_len;    // write bit length into last two words
    logic start_cmp;  // copy chain into working vars
    logic round;      // run one round
    logic fold;       // add working vars into chain
    logic emit_load;  // latch next digest word into output
    logic finish;     // reset chain and byte count
  } sha_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic block_full;  // byte position was 63
    logic two_blocks;  // padding needs an extra block
    logic last_round;
    logic last_word;
  } sha_stat_t;

  localparam logic [31:0] InitHash [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

FILE: design/sha256_ctrl.sv
// Sequencing state machine for the SHA-256 message hasher.
module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  sha_in_t    in_data,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  sha_stat_t  stat,
  output sha_cmd_t   cmd
);

  sha_state_t state_r, state_nxt;
  logic       final_r, final_nxt;   // compression belongs to message end
  logic       tail_r, tail_nxt;     // a length-only block still follows
  logic       ovalid_r, ovalid_nxt;
  logic       end_r, end_nxt;

  logic acc;
  assign in_stall  = (state_r != ST_IDLE);
  assign acc       = in_valid && !in_stall;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    final_nxt  = final_r;
    tail_nxt   = tail_r;
    ovalid_nxt = ovalid_r;
    end_nxt    = end_r;
    if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          end_nxt = in_data.message_end;
          if (!in_data.message_empty) state_nxt = ST_LOAD;
          else if (in_data.message_end) state_nxt = ST_PAD;
        end
      end
      ST_LOAD: begin
        if (stat.block_full) begin
          final_nxt = 1'b0;
          state_nxt = ST_ROUND;
        end else if (end_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        final_nxt = 1'b1;
        tail_nxt  = stat.two_blocks;
        state_nxt = stat.two_blocks ? ST_ROUND : ST_LEN;
      end
      ST_LEN: begin
        tail_nxt  = 1'b0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (stat.last_round) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        if (!final_r) state_nxt = end_r ? ST_PAD : ST_IDLE;
        else if (tail_r) state_nxt = ST_LEN;
        else state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ovalid_r || !out_stall) begin
          ovalid_nxt = 1'b1;
          if (stat.last_word) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:  cmd.load_byte = acc && !in_data.message_empty;
      ST_LOAD:  cmd.start_cmp = stat.block_full;
      ST_PAD: begin
        cmd.pad_start = 1'b1;
        cmd.start_cmp = stat.two_blocks;
      end
      ST_LEN: begin
        cmd.put_len   = 1'b1;
        cmd.clear_blk = tail_r;
        cmd.start_cmp = 1'b1;
      end
      ST_ROUND: cmd.round = 1'b1;
      ST_FOLD:  cmd.fold  = 1'b1;
      ST_EMIT: begin
        cmd.emit_load = !ovalid_r || !out_stall;
        cmd.finish    = cmd.emit_load && stat.last_word;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      final_r  <= 1'b0;
      tail_r   <= 1'b0;
      ovalid_r <= 1'b0;
      end_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      final_r  <= final_nxt;
      tail_r   <= tail_nxt;
      ovalid_r <= ovalid_nxt;
      end_r    <= end_nxt;
    end
  end

endmodule

FILE: design/sha256_dpath.sv
// Block store, message schedule, round logic and chaining value.
module sha256_dpath
  import sha256_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  sha_in_t    in_data,
  input  sha_cmd_t   cmd,
  output sha_stat_t  stat,
  output sha_out_t   out_data
);

  logic [31:0] blk_r   [BlockWords];   // schedule window, w[t..t+15]
  logic [31:0] chain_r [DigestWords];
  logic [31:0] v_r     [DigestWords];
  logic [60:0] total_r;
  logic [5:0]  rnd_r;
  logic [2:0]  wsel_r;
  sha_out_t    out_r;

  logic [5:0]  pos, lpos;
  logic [3:0]  pw;
  logic [1:0]  pb;
  logic [31:0] s0, s1, wnew, e1, ch, a0, maj, t1, t2;
  logic [63:0] bits;

  assign pos  = total_r[5:0];
  assign lpos = total_r[5:0] - 6'd1;
  assign pw   = pos[5:2];
  assign pb   = pos[1:0];
  assign bits = {total_r, 3'b000};

  assign s0   = rotr(blk_r[1], 7) ^ rotr(blk_r[1], 18) ^ (blk_r[1] >> 3);
  assign s1   = rotr(blk_r[14], 17) ^ rotr(blk_r[14], 19) ^ (blk_r[14] >> 10);
  assign wnew = blk_r[0] + s0 + blk_r[9] + s1;
  assign e1   = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1   = v_r[7] + e1 + ch + RoundK[rnd_r] + blk_r[0];
  assign a0   = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2   = a0 + maj;

  // block_full is looked at the cycle after the byte went in
  assign stat.block_full = (lpos == 6'd63) && (total_r != '0 || 1'b1) && (pos == 6'd0);
  assign stat.two_blocks = (pos >= LenPos);
  assign stat.last_round = (rnd_r == 6'(Rounds - 1));
  assign stat.last_word  = (wsel_r == 3'(DigestWords - 1));
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      case (pb)
        2'd0: blk_r[pw] <= {in_data.data_byte, 24'h0};
        2'd1: blk_r[pw][23:16] <= in_data.data_byte;
        2'd2: blk_r[pw][15:8] <= in_data.data_byte;
        default: blk_r[pw][7:0] <= in_data.data_byte;
      endcase
    end else if (cmd.pad_start) begin
      for (int i = 0; i < BlockWords; i++) begin
        if (4'(i) > pw) blk_r[i] <= '0;
      end
      case (pb)
        2'd0: blk_r[pw] <= {PadMark, 24'h0};
        2'd1: blk_r[pw] <= {blk_r[pw][31:24], PadMark, 16'h0};
        2'd2: blk_r[pw] <= {blk_r[pw][31:16], PadMark, 8'h0};
        default: blk_r[pw] <= {blk_r[pw][31:8], PadMark};
      endcase
    end else if (cmd.put_len) begin
      if (cmd.clear_blk) begin
        for (int i = 0; i < BlockWords - 2; i++) blk_r[i] <= '0;
      end
      blk_r[14] <= bits[63:32];
      blk_r[15] <= bits[31:0];
    end else if (cmd.round) begin
      for (int i = 0; i < BlockWords - 1; i++) blk_r[i] <= blk_r[i+1];
      blk_r[BlockWords-1] <= wnew;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_cmp) begin
      for (int i = 0; i < DigestWords; i++) v_r[i] <= chain_r[i];
    end else if (cmd.round) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DigestWords; i++) chain_r[i] <= InitHash[i];
      total_r <= '0;
      rnd_r   <= '0;
      wsel_r  <= '0;
    end else begin
      if (cmd.load_byte) total_r <= total_r + 61'd1;
      if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (cmd.fold) begin
        for (int i = 0; i < DigestWords; i++) chain_r[i] <= chain_r[i] + v_r[i];
      end
      if (cmd.emit_load) wsel_r <= wsel_r + 3'd1;
      if (cmd.finish) begin
        for (int i = 0; i < DigestWords; i++) chain_r[i] <= InitHash[i];
        total_r <= '0;
        wsel_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_r.digest_word <= chain_r[wsel_r];
      out_r.word_number <= wsel_r;
      out_r.digest_done <= stat.last_word;
    end
  end

endmodule

FILE: design/sha256_message_hasher_core.sv
// Top level of the SHA-256 message hasher.
//
// Input channel (in_valid / in_stall / in_data): one item carries one message
// byte, a message-end flag and an empty flag. An empty item with end set
// closes the message with the bytes taken so far; an empty item without end
// is taken and dropped.
// Output channel (out_valid / out_stall / out_data): a message end yields
// eight items, digest word 0 first, digest_done set on word 7.
// Sequence: an ordinary byte is accepted and written into the block, then the
// block is checked for being full or for a message end. The 64th byte of a
// block starts 64 rounds on the one-round-per-cycle compression unit and then
// a fold into the chain. A message end adds one or two further compressions
// and then the eight digest items, one per cycle unless the receiver stalls.
// in_stall is high whenever the block is busy; a stalled output item holds
// its value until taken, and further digest words wait behind it.
// Reset (rst_n low, synchronous) loads the initial hash, clears the byte count
// and drops any pending output item.
module sha256_message_hasher_core
  import sha256_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sha_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sha_out_t out_data
);

  sha_cmd_t  cmd;
  sha_stat_t stat;

  // sequence the per-item work
  sha256_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // hold block, schedule and hash state
  sha256_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

FILE: dv/sha256_message_hasher_core_tb.sv
// Self-checking testbench for the SHA-256 message hasher core.
`timescale 1ns / 100ps

module sha256_message_hasher_core_tb;
  import sha256_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  sha_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  sha_out_t out_data;

  sha256_message_hasher_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Round constants and initial hash, kept locally for the digest predictor.
  localparam logic [31:0] H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Predictor state.
  logic [31:0] hash_acc [8];
  logic [31:0] blk [16];
  logic [60:0] msg_bytes;

  sha_in_t  pending_items [$];
  sha_out_t digest_queue  [$];
  int       fail_count;
  int       send_idle_pct;
  int       recv_stall_pct;
  bit       in_fire;         // input item taken at the last rising edge

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run one 64-round compression of blk into hash_acc.
  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_acc[i] += v[i];
  endtask

  task automatic put_byte(int pos, logic [7:0] b);
    int sh;
    sh = (3 - (pos & 3)) * 8;
    if ((pos & 3) == 0) blk[pos >> 2] = 32'(b) << sh;
    else blk[pos >> 2] |= 32'(b) << sh;
  endtask

  // Advance the digest predictor by one accepted item.
  task automatic predict_digest(sha_in_t it);
    int pos;
    logic [63:0] bits;
    sha_out_t o;
    if (!it.message_empty) begin
      pos = int'(msg_bytes[5:0]);
      put_byte(pos, it.data_byte);
      msg_bytes = msg_bytes + 61'd1;
      if (pos == 63) compress();
    end
    if (it.message_end) begin
      pos = int'(msg_bytes[5:0]);
      put_byte(pos, 8'h80);
      for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
      if (pos >= 56) begin
        compress();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      bits = {msg_bytes, 3'b000};
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      compress();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hash_acc[i];
        o.word_number = 3'(i);
        o.digest_done = (i == 7);
        digest_queue = {digest_queue, o};
      end
      for (int i = 0; i < 8; i++) hash_acc[i] = H0[i];
      msg_bytes = '0;
    end
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // Queue a message of n bytes; optionally close with an empty end item.
  task automatic add_message(int n, bit empty_close, bit noise);
    sha_in_t it;
    for (int i = 0; i < n; i++) begin
      it.data_byte = 8'($urandom);
      it.message_empty = 1'b0;
      it.message_end = (i == n - 1) && !empty_close;
      pending_items = {pending_items, it};
      if (noise && $urandom_range(0, 9) == 0) begin
        it.data_byte = 8'($urandom);
        it.message_empty = 1'b1;
        it.message_end = 1'b0;
        pending_items = {pending_items, it};
      end
    end
    if (empty_close || n == 0) begin
      it.data_byte = 8'($urandom);
      it.message_empty = 1'b1;
      it.message_end = 1'b1;
      pending_items = {pending_items, it};
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: change inputs on the falling edge, hold while stalled.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_fire) begin
        // still stalled: hold the item
      end else if (pending_items.size() > 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: sample both channels at the rising edge.
  always @(posedge clk) begin
    sha_out_t exp_item;
    in_fire = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_fire) predict_digest(in_data);
      if (out_valid && !out_stall) begin
        if (digest_queue.size() == 0) begin
          report_mismatch("digest item with nothing expected");
        end else begin
          exp_item = digest_queue.pop_front();
          if (out_data.digest_word !== exp_item.digest_word)
            report_mismatch($sformatf("digest_word %h, expected %h",
                            out_data.digest_word, exp_item.digest_word));
          if (out_data.word_number !== exp_item.word_number)
            report_mismatch($sformatf("word_number %0d, expected %0d",
                            out_data.word_number, exp_item.word_number));
          if (out_data.digest_done !== exp_item.digest_done)
            report_mismatch($sformatf("digest_done %0b, expected %0b",
                            out_data.digest_done, exp_item.digest_done));
        end
      end
    end
  end

  // Wait until the driver has emptied its queue and the item has gone in.
  task automatic drain_input();
    while (pending_items.size() > 0 || in_valid) @(posedge clk);
  endtask

  task automatic drain_all();
    drain_input();
    while (digest_queue.size() > 0) @(posedge clk);
  endtask

  initial begin
    sha_in_t it;
    int sent;
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fail_count = 0;
    in_fire = 1'b0;
    msg_bytes = '0;
    for (int i = 0; i < 8; i++) hash_acc[i] = H0[i];
    for (int i = 0; i < 16; i++) blk[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty message, stray empty items, byte extremes, short messages.
    add_message(0, 1'b1, 1'b0);
    it = '{data_byte: 8'hff, message_end: 1'b0, message_empty: 1'b1};
    pending_items = {pending_items, it};
    it = '{data_byte: 8'hff, message_end: 1'b1, message_empty: 1'b0};
    pending_items = {pending_items, it};
    it = '{data_byte: 8'h00, message_end: 1'b1, message_empty: 1'b0};
    pending_items = {pending_items, it};
    it = '{data_byte: 8'h55, message_end: 1'b0, message_empty: 1'b0};
    pending_items = {pending_items, it};
    it = '{data_byte: 8'haa, message_end: 1'b0, message_empty: 1'b1};
    pending_items = {pending_items, it};
    it = '{data_byte: 8'haa, message_end: 1'b1, message_empty: 1'b0};
    pending_items = {pending_items, it};
    add_message(3, 1'b1, 1'b0);
    add_message(10, 1'b0, 1'b0);
    drain_all();

    // Pause the sender until every digest word is out: padding that spills
    // into a second block, and exactly one full block.
    add_message(56, 1'b0, 1'b0);
    drain_all();
    add_message(64, 1'b1, 1'b0);
    add_message(55, 1'b0, 1'b0);
    drain_all();

    // Random phases with differing idle and stall pressure.
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int m = 0; m < 10; m++) begin
        int n;
        case ($urandom_range(0, 4))
          0: n = $urandom_range(0, 3);
          1: n = $urandom_range(54, 66);
          default: n = $urandom_range(1, 20);
        endcase
        add_message(n, $urandom_range(0, 3) == 0, 1'b1);
        sent += n;
        if (sent > 50 * (ph + 1)) break;
      end
      drain_all();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (200) @(posedge clk);
    if (fail_count == 0 && digest_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
design/sha256_pkg.sv
design/sha256_ctrl.sv
design/sha256_dpath.sv
design/sha256_message_hasher_core.sv
dv/sha256_message_hasher_core_tb.sv
